// ===== rtl/core/dcbf_pkg.sv =====
// Shared types and constants of the DC blocking filter bank.
`default_nettype none

package dcbf_pkg;

  localparam int unsigned Channels = 4;
  localparam int unsigned ChW      = 2;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ProdW    = SampleW + CoefW;
  localparam int unsigned MulSteps = CoefW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  typedef enum logic {
    REG_NUM = 1'b0,
    REG_DEN = 1'b1
  } reg_sel_e;

  typedef struct packed {
    logic             start;
    logic [CoefW-1:0] num;
    logic [CoefW-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/dc_blocking_filter_bank_top.sv =====
// Top level of the four-channel one-pole DC blocking filter bank.
//
//  channel  | handshake               | beat payload
//  ---------+-------------------------+-----------------------------
//  in       | in_valid_i / in_stall_o | channel_i, sample_in_i
//  out      | out_valid_o/ out_stall_i| sample_out_o, overflow_o
//  cfg      | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each item runs from input beat to output register through a bit-serial
// multiply and a restoring divide in dcbf_muldiv, a hand-over of the quotient,
// then an accumulate and an output state (the divide is skipped with a zero den).
// A new beat is taken the cycle after the result has moved to the output
// register, even while that register is stalled.
// Reset clears the coefficients (num 0, den 1) and all accumulators.
// Configuration writes are always ready.
`default_nettype none

module dc_blocking_filter_bank_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [dcbf_pkg::ChW-1:0]       channel_i,
  input  wire logic signed [dcbf_pkg::SampleW-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [dcbf_pkg::SampleW-1:0] sample_out_o,
  output logic                                overflow_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dcbf_pkg::RegIdxW-1:0]   cfg_index_i,
  input  wire logic [dcbf_pkg::CoefW-1:0]     cfg_data_i
);

  localparam int unsigned W = dcbf_pkg::SampleW;
  localparam int unsigned SumW = dcbf_pkg::ProdW + 2;

  dcbf_pkg::state_e           state_q, state_d;
  logic [dcbf_pkg::ChW-1:0]   ch_q, ch_d;
  logic                       chok_q, chok_d;
  logic signed [W-1:0]        x_q, x_d;
  logic signed [W-1:0]        prev_q, prev_d;
  logic signed [W-1:0]        acc_q, acc_d;
  logic                       ovf_q, ovf_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [W-1:0]        out_data_q, out_data_d;
  logic                       out_ovf_q, out_ovf_d;
  logic                       wr_en;

  logic [dcbf_pkg::CoefW-1:0] num_q [dcbf_pkg::Channels];
  logic [dcbf_pkg::CoefW-1:0] den_q [dcbf_pkg::Channels];
  logic signed [W-1:0]        prev_accum_q [dcbf_pkg::Channels];

  dcbf_pkg::md_req_t          md_req;
  dcbf_pkg::md_stat_t         md_stat;
  logic [dcbf_pkg::ProdW-1:0] md_quot;

  logic                       in_acc;
  logic                       ch_ok;
  logic signed [W-1:0]        prev_sel;
  logic [W-1:0]               prev_mag;
  logic signed [SumW-1:0]     fb;
  logic signed [SumW-1:0]     acc_sum;
  logic signed [W:0]          diff;
  logic                       out_free;

  localparam logic signed [W-1:0] I32Max = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] I32Min = {1'b1, {(W-1){1'b0}}};

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != dcbf_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign ch_ok       = {1'b0, channel_i} < (dcbf_pkg::ChW + 1)'(dcbf_pkg::Channels);
  assign out_free    = !out_valid_q || !out_stall_i;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dcbf_pkg::Channels; i++) begin
        num_q[i] <= '0;
        den_q[i] <= dcbf_pkg::CoefW'(1);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dcbf_pkg::reg_sel_e'(cfg_index_i[0]))
        dcbf_pkg::REG_NUM: num_q[cfg_index_i[dcbf_pkg::RegIdxW-1:1]] <= cfg_data_i;
        dcbf_pkg::REG_DEN: den_q[cfg_index_i[dcbf_pkg::RegIdxW-1:1]] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    prev_sel = prev_accum_q[channel_i];
    prev_mag = prev_sel[W-1] ? (~prev_sel + 1'b1) : prev_sel;
    fb       = prev_q[W-1] ? -$signed({2'b00, md_quot}) : $signed({2'b00, md_quot});
    acc_sum  = SumW'(x_q) + fb;
    diff     = (W+1)'(acc_q) - (W+1)'(prev_q);
  end

  assign md_req.start = in_acc && ch_ok;
  assign md_req.num   = num_q[channel_i];
  assign md_req.den   = den_q[channel_i];

  dcbf_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .mag_i  (prev_mag),
    .stat_o (md_stat),
    .quot_o (md_quot)
  );

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    chok_d      = chok_q;
    x_d         = x_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    out_ovf_d   = out_ovf_q;
    wr_en       = 1'b0;
    unique case (state_q)
      dcbf_pkg::ST_IDLE: begin
        if (in_acc) begin
          ch_d    = channel_i;
          chok_d  = ch_ok;
          x_d     = sample_in_i;
          prev_d  = prev_accum_q[channel_i];
          ovf_d   = 1'b0;
          state_d = ch_ok ? dcbf_pkg::ST_CALC : dcbf_pkg::ST_OUT;
        end
      end
      dcbf_pkg::ST_CALC: begin
        if (md_stat.done) begin
          state_d = dcbf_pkg::ST_ACC;
        end
      end
      dcbf_pkg::ST_ACC: begin
        if (acc_sum > SumW'(I32Max)) begin
          acc_d = I32Max;
          ovf_d = 1'b1;
        end else if (acc_sum < SumW'(I32Min)) begin
          acc_d = I32Min;
          ovf_d = 1'b1;
        end else begin
          acc_d = acc_sum[W-1:0];
        end
        state_d = dcbf_pkg::ST_OUT;
      end
      dcbf_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (!chok_q) begin
            out_data_d = '0;
            out_ovf_d  = 1'b0;
          end else if (diff > (W+1)'(I32Max)) begin
            out_data_d = I32Max;
            out_ovf_d  = 1'b1;
          end else if (diff < (W+1)'(I32Min)) begin
            out_data_d = I32Min;
            out_ovf_d  = 1'b1;
          end else begin
            out_data_d = diff[W-1:0];
            out_ovf_d  = ovf_q;
          end
          wr_en   = chok_q;
          state_d = dcbf_pkg::ST_IDLE;
        end
      end
      default: state_d = dcbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcbf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < dcbf_pkg::Channels; i++) begin
        prev_accum_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        prev_accum_q[ch_q] <= acc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    chok_q     <= chok_d;
    x_q        <= x_d;
    prev_q     <= prev_d;
    acc_q      <= acc_d;
    ovf_q      <= ovf_d;
    out_data_q <= out_data_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;
  assign overflow_o   = out_ovf_q;

`ifndef SYNTH
  a_done_in_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_stat.done |-> state_q == dcbf_pkg::ST_CALC)
    else $error("muldiv finished outside the calc phase");

  a_idle_unit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dcbf_pkg::ST_IDLE |-> !md_stat.busy)
    else $error("muldiv busy while idle");

  a_out_from_out_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == dcbf_pkg::ST_OUT)
    else $error("output beat raised outside the output phase");

  a_start_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> state_q == dcbf_pkg::ST_IDLE && !md_stat.busy)
    else $error("muldiv started while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dcbf_muldiv.sv =====
// Bit-serial unsigned multiply then restoring divide: quot = (mag * num) / den.
`default_nettype none

module dcbf_muldiv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dcbf_pkg::md_req_t             req_i,
  input  wire logic [dcbf_pkg::SampleW-1:0]  mag_i,
  output dcbf_pkg::md_stat_t                 stat_o,
  output logic [dcbf_pkg::ProdW-1:0]         quot_o
);

  dcbf_pkg::md_state_e              state_q, state_d;
  logic [dcbf_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             done_q, done_d;
  logic [dcbf_pkg::ProdW-1:0]       p_q, p_d;
  logic [dcbf_pkg::CoefW-1:0]       n_q, n_d;
  logic [dcbf_pkg::CoefW-1:0]       den_q, den_d;
  logic [dcbf_pkg::SampleW-1:0]     mag_q, mag_d;
  logic [dcbf_pkg::CoefW-1:0]       rem_q, rem_d;

  logic [dcbf_pkg::SampleW:0]       mul_sum;
  logic [dcbf_pkg::CoefW:0]         rem_sh;
  logic [dcbf_pkg::CoefW:0]         rem_sub;
  logic                             fits;

  always_comb begin
    mul_sum = {1'b0, p_q[dcbf_pkg::ProdW-1:dcbf_pkg::CoefW]}
            + {1'b0, (n_q[0] ? mag_q : {dcbf_pkg::SampleW{1'b0}})};
    rem_sh  = {rem_q, p_q[dcbf_pkg::ProdW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    p_d     = p_q;
    n_d     = n_q;
    den_d   = den_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    unique case (state_q)
      dcbf_pkg::MD_IDLE: begin
        if (req_i.start) begin
          p_d     = '0;
          n_d     = req_i.num;
          den_d   = req_i.den;
          mag_d   = mag_i;
          cnt_d   = '0;
          state_d = dcbf_pkg::MD_MUL;
        end
      end
      dcbf_pkg::MD_MUL: begin
        p_d   = {mul_sum, p_q[dcbf_pkg::CoefW-1:1]};
        n_d   = n_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dcbf_pkg::CntW'(dcbf_pkg::MulSteps - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (den_q == '0) begin
            // zero denominator: feedback forced to zero
            p_d     = '0;
            done_d  = 1'b1;
            state_d = dcbf_pkg::MD_IDLE;
          end else begin
            state_d = dcbf_pkg::MD_DIV;
          end
        end
      end
      dcbf_pkg::MD_DIV: begin
        rem_d = fits ? rem_sub[dcbf_pkg::CoefW-1:0] : rem_sh[dcbf_pkg::CoefW-1:0];
        p_d   = {p_q[dcbf_pkg::ProdW-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dcbf_pkg::CntW'(dcbf_pkg::DivSteps - 1)) begin
          done_d  = 1'b1;
          state_d = dcbf_pkg::MD_IDLE;
        end
      end
      default: state_d = dcbf_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcbf_pkg::MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    n_q   <= n_d;
    den_q <= den_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = (state_q != dcbf_pkg::MD_IDLE);
  assign stat_o.done = done_q;
  assign quot_o      = p_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the four-channel DC blocking filter bank.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ItemLatency   = 68;
  localparam int     WatchdogLimit = 4000;
  localparam int     PhaseItems    = 200;
  localparam longint I32Max        = 64'sd2147483647;
  localparam longint I32Min        = -64'sd2147483648;

  typedef struct packed {
    logic signed [dcbf_pkg::SampleW-1:0] sample;
    logic                                ovf;
  } filt_out_t;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  logic [dcbf_pkg::ChW-1:0]            channel_i   = '0;
  logic signed [dcbf_pkg::SampleW-1:0] sample_in_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [dcbf_pkg::SampleW-1:0] sample_out_o;
  logic                                overflow_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [dcbf_pkg::RegIdxW-1:0]        cfg_index_i = '0;
  logic [dcbf_pkg::CoefW-1:0]          cfg_data_i  = '0;

  logic signed [dcbf_pkg::SampleW-1:0] accum_q    [dcbf_pkg::Channels];
  logic [dcbf_pkg::CoefW-1:0]          coef_num_q [dcbf_pkg::Channels];
  logic [dcbf_pkg::CoefW-1:0]          coef_den_q [dcbf_pkg::Channels];
  logic [dcbf_pkg::CoefW-1:0]          next_num   [dcbf_pkg::Channels];
  logic [dcbf_pkg::CoefW-1:0]          next_den   [dcbf_pkg::Channels];
  logic signed [dcbf_pkg::SampleW-1:0] dc_level   [dcbf_pkg::Channels];
  filt_out_t                           pending_out[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int n_errors      = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_settings    = 0;
  int n_sat         = 0;
  int n_zero_den    = 0;
  int idle_cycles   = 0;

  dc_blocking_filter_bank_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .overflow_o   (overflow_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp_i32(input longint v, inout bit hit);
    if (v > I32Max) begin
      hit = 1'b1;
      return I32Max;
    end
    if (v < I32Min) begin
      hit = 1'b1;
      return I32Min;
    end
    return v;
  endfunction

  // one filter update for the selected channel
  function automatic filt_out_t filter_step(input logic [dcbf_pkg::ChW-1:0] ch,
                                            input logic signed [dcbf_pkg::SampleW-1:0] x);
    longint    prev, gain, den, xs, fb, acc, y;
    bit        hit;
    filt_out_t res;
    prev = accum_q[ch];
    gain = coef_num_q[ch];
    den  = coef_den_q[ch];
    xs   = x;
    hit  = 1'b0;
    fb   = (den != 0) ? (gain * prev) / den : 0;
    acc  = clamp_i32(xs + fb, hit);
    y    = clamp_i32(acc - prev, hit);
    res.sample = y[dcbf_pkg::SampleW-1:0];
    res.ovf    = hit;
    accum_q[ch] = acc[dcbf_pkg::SampleW-1:0];
    if (den == 0) n_zero_den++;
    if (hit) n_sat++;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_out
    filt_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected output beat", sample_out_o, 0);
      end else begin
        want = pending_out.pop_front();
        n_checked++;
        if (sample_out_o !== want.sample)
          report_mismatch("sample_out", sample_out_o, want.sample);
        if (overflow_o !== want.ovf)
          report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [dcbf_pkg::ChW-1:0] ch,
                             input logic signed [dcbf_pkg::SampleW-1:0] x);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= x;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_out.push_back(filter_step(ch, x));
    n_sent++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_out.size() != 0);
  endtask

  // writes all eight coefficient registers from next_num / next_den
  task automatic load_coefs();
    dcbf_pkg::reg_sel_e sel;
    cfg_valid_i <= 1'b1;
    for (int ch = 0; ch < dcbf_pkg::Channels; ch++) begin
      for (int s = 0; s < 2; s++) begin
        sel = dcbf_pkg::reg_sel_e'(s);
        cfg_index_i <= {ch[dcbf_pkg::ChW-1:0], sel};
        cfg_data_i  <= (sel == dcbf_pkg::REG_DEN) ? next_den[ch] : next_num[ch];
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        if (sel == dcbf_pkg::REG_DEN) coef_den_q[ch] = next_den[ch];
        else coef_num_q[ch] = next_num[ch];
      end
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic pick_coefs();
    int unsigned d;
    for (int ch = 0; ch < dcbf_pkg::Channels; ch++) begin
      case ($urandom_range(9))
        0: begin
          next_num[ch] = '0;
          next_den[ch] = $urandom_range(65535, 1);
        end
        1: begin
          next_num[ch] = 16'hfffe;
          next_den[ch] = 16'hffff;
        end
        2: begin
          next_num[ch] = $urandom;
          next_den[ch] = '0;
        end
        3: begin
          next_num[ch] = $urandom;
          next_den[ch] = $urandom;
        end
        4: begin
          next_num[ch] = 16'hffff;
          next_den[ch] = 16'h0001;
        end
        default: begin
          // pole close to one, as in real use
          d = $urandom_range(65535, 2);
          next_den[ch] = d;
          next_num[ch] = d - $urandom_range((d > 256) ? 256 : d - 1, 1);
        end
      endcase
      dc_level[ch] = $signed($urandom) >>> $urandom_range(31, 1);
    end
  endtask

  function automatic logic signed [dcbf_pkg::SampleW-1:0] pick_sample(
      input logic [dcbf_pkg::ChW-1:0] ch);
    case ($urandom_range(19))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      3: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      default: return dc_level[ch] + $signed($urandom_range(4095)) - 32'sd2048;
    endcase
  endfunction

  task automatic test_reset_coefs();
    send_sample(0, '0);
    send_sample(0, 32'sh7fff_ffff);
    send_sample(0, 32'sh8000_0000);
    send_sample(1, -32'sd1);
    send_sample(2, 32'sd1);
    send_sample(3, 32'sh5555_aaaa);
    send_sample(3, 32'shaaaa_5555);
    wait_results_done();
  endtask

  task automatic test_edge_coefs();
    // ch0 no feedback, ch1 max gain, ch2 zero denominator, ch3 pole just below one
    next_num = '{16'h0000, 16'hffff, 16'h3039, 16'hfffe};
    next_den = '{16'hffff, 16'h0001, 16'h0000, 16'hffff};
    load_coefs();
    send_sample(1, 32'sh4000_0000);
    send_sample(1, 32'sh4000_0000);
    send_sample(1, 32'sh8000_0000);
    send_sample(2, 32'sd1000);
    send_sample(2, -32'sd1000);
    send_sample(2, 32'sh7fff_ffff);
    send_sample(3, 32'sh7fff_ffff);
    send_sample(3, 32'sh7fff_ffff);
    send_sample(3, 32'sh8000_0000);
    send_sample(0, 32'sd5);
    send_sample(0, 32'sh8000_0000);
    wait_results_done();
    // coefficient of exactly one
    next_num = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    next_den = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    load_coefs();
    send_sample(0, 32'sh7fff_ffff);
    send_sample(0, 32'sh7fff_ffff);
    send_sample(0, 32'sh7fff_ffff);
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct);
    logic [dcbf_pkg::ChW-1:0] ch;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    for (int ph = 0; ph < 3; ph++) begin
      pick_coefs();
      load_coefs();
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) wait_results_done();
        ch = $urandom_range(dcbf_pkg::Channels - 1);
        send_sample(ch, pick_sample(ch));
      end
      wait_results_done();
    end
  endtask

  initial begin
    for (int ch = 0; ch < dcbf_pkg::Channels; ch++) begin
      accum_q[ch]    = '0;
      coef_num_q[ch] = '0;
      coef_den_q[ch] = 16'h0001;
    end
    in_idle_pct   = 31;
    out_stall_pct = 47;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_coefs();
    test_edge_coefs();
    test_random_traffic(31, 47);
    test_random_traffic(47, 31);
    test_random_traffic(0, 0);
    repeat (ItemLatency + 12) @(posedge clk_i);
    if (pending_out.size() != 0)
      report_mismatch("results never delivered", pending_out.size(), 0);
    $display("Covered %0d samples over %0d coefficient settings and three idle/stall mixes",
             n_sent, n_settings);
    $display("%0d beats checked, %0d saturating, %0d with zero denominator, %0d mismatches",
             n_checked, n_sat, n_zero_den, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dcbf_pkg.sv
rtl/core/dcbf_muldiv.sv
rtl/core/dc_blocking_filter_bank_top.sv
tb/sv/testbench.sv
